>>> rtl/kdrq_pkg.sv
// Shared types and codes for the keyed dedup request queue.
// No dependencies; every other file in rtl/ imports this package.
package kdrq_pkg;

  localparam int ENTRIES_DEF = 64;

  localparam int OP_W    = 3;
  localparam int CID_W   = 16;
  localparam int RID_W   = 32;
  localparam int BYTES_W = 16;
  localparam int ST_W    = 2;
  localparam int CNT_OUT_W = 7;
  localparam int SUM_OUT_W = 22;

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP    = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_DUP     = 2'd1;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

  // Per-cell command from the controller.
  typedef struct packed {
    logic look;   // register the key compare
    logic clear;  // drop the entry
    logic shift;  // take the neighbor's entry (close a gap)
    logic load;   // write the new key at the tail
  } cell_ctl_t;

endpackage

>>> rtl/keyed_dedup_request_queue.sv
// Top level of the keyed dedup request queue: controller plus a row of cells.
// Depends on kdrq_pkg, kdrq_cell and kdrq_ctrl.
//
// Usage:
//   Command channel: drive opcode, client_tag, request_seq and req_bytes with
//   start high; the beat is taken at a clock edge where busy is low.
//   Result channel: done is high for exactly one cycle and marks a valid
//   result beat on status, was_head, out_client_id, out_request_id,
//   out_bytes, entry_count and byte_total. The receiver cannot stall it.
// Path: a taken beat goes through the compare phase, then the update phase,
//   then the result registers.
// Overlap: busy is high only during the compare phase, so a new command is
//   taken at the same edge that commits the previous update; the row
//   compares against the updated entries.
// Storage: entries sit packed in arrival order in a row of cells, the oldest
//   in cell 0. Remove and pop make every cell from the freed one onward take
//   its neighbor's entry in one step; append loads the cell at the count.
// Reset: synchronous, active high; all cells empty, count and total zero,
//   no result pending. No clearing pass is needed.
module keyed_dedup_request_queue #(
  parameter int ENTRIES = kdrq_pkg::ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [kdrq_pkg::OP_W-1:0]        opcode,
  input  logic [kdrq_pkg::CID_W-1:0]       client_tag,
  input  logic [kdrq_pkg::RID_W-1:0]       request_seq,
  input  logic [kdrq_pkg::BYTES_W-1:0]     req_bytes,
  output logic                            done,
  output logic [kdrq_pkg::ST_W-1:0]        status,
  output logic                            was_head,
  output logic [kdrq_pkg::CID_W-1:0]       out_client_id,
  output logic [kdrq_pkg::RID_W-1:0]       out_request_id,
  output logic [kdrq_pkg::BYTES_W-1:0]     out_bytes,
  output logic [kdrq_pkg::CNT_OUT_W-1:0]   entry_count,
  output logic [kdrq_pkg::SUM_OUT_W-1:0]   byte_total
);
  import kdrq_pkg::*;

  // Broadcast key and command for the row.
  logic [CID_W-1:0]   key_client;
  logic [RID_W-1:0]   key_request;
  logic [BYTES_W-1:0] key_bytes;
  cell_ctl_t          ctl [ENTRIES];

  // Per-cell state seen by the neighbor and the controller.
  logic               c_valid   [ENTRIES];
  logic [CID_W-1:0]   c_client  [ENTRIES];
  logic [RID_W-1:0]   c_request [ENTRIES];
  logic [BYTES_W-1:0] c_bytes   [ENTRIES];
  logic [BYTES_W-1:0] c_mbytes  [ENTRIES];
  logic [ENTRIES-1:0] match_vec;

  kdrq_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .client_tag     (client_tag),
    .request_seq    (request_seq),
    .req_bytes      (req_bytes),
    .key_client     (key_client),
    .key_request    (key_request),
    .key_bytes      (key_bytes),
    .ctl            (ctl),
    .match_vec      (match_vec),
    .match_bytes    (c_mbytes),
    .head_client    (c_client[0]),
    .head_request   (c_request[0]),
    .head_bytes     (c_bytes[0]),
    .done           (done),
    .status         (status),
    .was_head       (was_head),
    .out_client_id  (out_client_id),
    .out_request_id (out_request_id),
    .out_bytes      (out_bytes),
    .entry_count    (entry_count),
    .byte_total     (byte_total)
  );

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic               n_valid;
    logic [CID_W-1:0]   n_client;
    logic [RID_W-1:0]   n_request;
    logic [BYTES_W-1:0] n_bytes;

    // The last cell has no neighbor: it drains to empty.
    if (i == ENTRIES - 1) begin : g_last
      assign n_valid   = 1'b0;
      assign n_client  = '0;
      assign n_request = '0;
      assign n_bytes   = '0;
    end else begin : g_mid
      assign n_valid   = c_valid[i+1];
      assign n_client  = c_client[i+1];
      assign n_request = c_request[i+1];
      assign n_bytes   = c_bytes[i+1];
    end

    kdrq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl[i]),
      .key_client  (key_client),
      .key_request (key_request),
      .key_bytes   (key_bytes),
      .nbr_valid   (n_valid),
      .nbr_client  (n_client),
      .nbr_request (n_request),
      .nbr_bytes   (n_bytes),
      .valid       (c_valid[i]),
      .client      (c_client[i]),
      .request     (c_request[i]),
      .bytes       (c_bytes[i]),
      .match       (match_vec[i]),
      .match_bytes (c_mbytes[i])
    );
  end

endmodule

>>> rtl/kdrq_cell.sv
// One queue cell: holds a single entry, compares it against the broadcast key
// and takes its upstream neighbor's entry when a gap closes. Uses kdrq_pkg.
module kdrq_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  kdrq_pkg::cell_ctl_t         ctl,
  input  logic [kdrq_pkg::CID_W-1:0]   key_client,
  input  logic [kdrq_pkg::RID_W-1:0]   key_request,
  input  logic [kdrq_pkg::BYTES_W-1:0] key_bytes,
  input  logic                        nbr_valid,
  input  logic [kdrq_pkg::CID_W-1:0]   nbr_client,
  input  logic [kdrq_pkg::RID_W-1:0]   nbr_request,
  input  logic [kdrq_pkg::BYTES_W-1:0] nbr_bytes,
  output logic                        valid,
  output logic [kdrq_pkg::CID_W-1:0]   client,
  output logic [kdrq_pkg::RID_W-1:0]   request,
  output logic [kdrq_pkg::BYTES_W-1:0] bytes,
  output logic                        match,
  output logic [kdrq_pkg::BYTES_W-1:0] match_bytes
);
  import kdrq_pkg::*;

  logic hit;

  assign hit = valid && (client == key_client) && (request == key_request);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctl.look) begin
        match <= hit;
      end
      if (ctl.clear) begin
        valid <= 1'b0;
      end else if (ctl.shift) begin
        valid <= nbr_valid;
      end else if (ctl.load) begin
        valid <= 1'b1;
      end
    end
  end

  // Payload carries no reset; valid qualifies it.
  always_ff @(posedge clk) begin
    if (ctl.look) begin
      match_bytes <= hit ? bytes : '0;
    end
    if (!ctl.clear && ctl.shift) begin
      client  <= nbr_client;
      request <= nbr_request;
      bytes   <= nbr_bytes;
    end else if (!ctl.clear && ctl.load) begin
      client  <= key_client;
      request <= key_request;
      bytes   <= key_bytes;
    end
  end

endmodule

>>> rtl/kdrq_ctrl.sv
// Controller: accepts a command beat, sequences the compare and update phases,
// keeps count and byte total, and registers the result beat. Uses kdrq_pkg.
module kdrq_ctrl #(
  parameter int ENTRIES = kdrq_pkg::ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [kdrq_pkg::OP_W-1:0]        opcode,
  input  logic [kdrq_pkg::CID_W-1:0]       client_tag,
  input  logic [kdrq_pkg::RID_W-1:0]       request_seq,
  input  logic [kdrq_pkg::BYTES_W-1:0]     req_bytes,
  output logic [kdrq_pkg::CID_W-1:0]       key_client,
  output logic [kdrq_pkg::RID_W-1:0]       key_request,
  output logic [kdrq_pkg::BYTES_W-1:0]     key_bytes,
  output kdrq_pkg::cell_ctl_t             ctl [ENTRIES],
  input  logic [ENTRIES-1:0]              match_vec,
  input  logic [kdrq_pkg::BYTES_W-1:0]     match_bytes [ENTRIES],
  input  logic [kdrq_pkg::CID_W-1:0]       head_client,
  input  logic [kdrq_pkg::RID_W-1:0]       head_request,
  input  logic [kdrq_pkg::BYTES_W-1:0]     head_bytes,
  output logic                            done,
  output logic [kdrq_pkg::ST_W-1:0]        status,
  output logic                            was_head,
  output logic [kdrq_pkg::CID_W-1:0]       out_client_id,
  output logic [kdrq_pkg::RID_W-1:0]       out_request_id,
  output logic [kdrq_pkg::BYTES_W-1:0]     out_bytes,
  output logic [kdrq_pkg::CNT_OUT_W-1:0]   entry_count,
  output logic [kdrq_pkg::SUM_OUT_W-1:0]   byte_total
);
  import kdrq_pkg::*;

  localparam int CNT_RAW = $clog2(ENTRIES + 1);
  localparam int CNT_W   = (CNT_RAW > CNT_OUT_W) ? CNT_RAW : CNT_OUT_W;
  localparam int SUM_RAW = BYTES_W + $clog2(ENTRIES);
  localparam int SUM_W   = (SUM_RAW > SUM_OUT_W) ? SUM_RAW : SUM_OUT_W;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LOOK = 2'd1;
  localparam logic [1:0] PH_EXEC = 2'd2;

  logic [1:0]         phase, phase_next;
  logic [OP_W-1:0]    op;
  logic [CNT_W-1:0]   count, count_next;
  logic [SUM_W-1:0]   total, total_next;
  logic               accept;
  logic               exec;

  logic               hit;
  logic [BYTES_W-1:0] hit_bytes;
  logic [ENTRIES-1:0] rm_sel;
  logic [ENTRIES-1:0] rm_mask;
  logic               do_load;
  logic               do_clear;
  logic [ST_W-1:0]    st_next;
  logic               wh_next;
  logic               pop_out;

  assign busy   = (phase == PH_LOOK);
  assign accept = start && !busy;
  assign exec   = (phase == PH_EXEC);
  assign hit    = |match_vec;

  always_comb begin
    hit_bytes = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_bytes = hit_bytes | match_bytes[i];
    end
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE: phase_next = accept ? PH_LOOK : PH_IDLE;
      PH_LOOK: phase_next = PH_EXEC;
      PH_EXEC: phase_next = accept ? PH_LOOK : PH_IDLE;
      default: phase_next = PH_IDLE;
    endcase
  end

  // Decide the update from the registered compare results.
  always_comb begin
    count_next = count;
    total_next = total;
    rm_sel     = '0;
    do_load    = 1'b0;
    do_clear   = 1'b0;
    st_next    = ST_OK;
    wh_next    = 1'b0;
    pop_out    = 1'b0;
    case (op)
      OP_APPEND: begin
        if (hit) begin
          st_next = ST_DUP;
        end else if (count == CNT_W'(ENTRIES)) begin
          st_next = ST_FULL;
        end else begin
          do_load    = 1'b1;
          count_next = count + CNT_W'(1);
          total_next = total + SUM_W'(key_bytes);
        end
      end
      OP_QUERY: begin
        st_next = hit ? ST_OK : ST_MISSING;
      end
      OP_POP: begin
        if (count == '0) begin
          st_next = ST_MISSING;
        end else begin
          pop_out    = 1'b1;
          rm_sel     = ENTRIES'(1);
          count_next = count - CNT_W'(1);
          total_next = total - SUM_W'(head_bytes);
        end
      end
      OP_REMOVE: begin
        if (!hit) begin
          st_next = ST_MISSING;
        end else begin
          wh_next    = match_vec[0];
          rm_sel     = match_vec;
          count_next = count - CNT_W'(1);
          total_next = total - SUM_W'(hit_bytes);
        end
      end
      OP_CLEAR: begin
        do_clear   = 1'b1;
        count_next = '0;
        total_next = '0;
      end
      default: begin
        st_next = ST_MISSING;
      end
    endcase
  end

  // The removed cell and every cell behind it take their neighbor's entry.
  assign rm_mask = ~(rm_sel - ENTRIES'(1));

  for (genvar i = 0; i < ENTRIES; i++) begin : g_ctl
    assign ctl[i].look  = busy;
    assign ctl[i].clear = exec && do_clear;
    assign ctl[i].shift = exec && rm_mask[i];
    assign ctl[i].load  = exec && do_load && (count == CNT_W'(i));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      count <= '0;
      total <= '0;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= exec;
      if (exec) begin
        count <= count_next;
        total <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op          <= opcode;
      key_client  <= client_tag;
      key_request <= request_seq;
      key_bytes   <= req_bytes;
    end
    if (exec) begin
      status         <= st_next;
      was_head       <= wh_next;
      out_client_id  <= pop_out ? head_client  : '0;
      out_request_id <= pop_out ? head_request : '0;
      out_bytes      <= pop_out ? head_bytes   : '0;
      entry_count    <= count_next[CNT_OUT_W-1:0];
      byte_total     <= total_next[SUM_OUT_W-1:0];
    end
  end

endmodule

>>> rtl/kdrq_checker.sv
// Port-level checks for keyed_dedup_request_queue, attached by bind.
// Depends on kdrq_pkg and the top level's ports.
module kdrq_checker #(
  parameter int ENTRIES = kdrq_pkg::ENTRIES_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [kdrq_pkg::ST_W-1:0]      status,
  input logic [kdrq_pkg::CNT_OUT_W-1:0] entry_count
);
  import kdrq_pkg::*;

  // Every taken command beat yields its result beat right after its update phase.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("result beat missing after command beat");

  // No command is taken during the compare phase, so results never abut.
  a_spacing: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result beats on consecutive cycles");

  // A taken beat holds off the next one for the compare phase.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after command beat");

  // A full refusal only happens with every entry held.
  a_full: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (entry_count == CNT_OUT_W'(ENTRIES)))
    else $error("full status with free entries");

  // Reset leaves no result beat pending.
  a_reset: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result beat right after reset");

endmodule

bind keyed_dedup_request_queue kdrq_checker #(
  .ENTRIES (ENTRIES)
) u_kdrq_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .entry_count (entry_count)
);
